FILE: rtl/rrsg_pkg.sv
package rrsg_pkg;

   localparam int COORD_BITS           = 16;
   localparam int SIZE_BITS            = COORD_BITS - 1;
   localparam int RAD_BITS             = SIZE_BITS - 1;
   localparam int SQ_BITS              = 2 * RAD_BITS;
   localparam int ROOT_BITS            = RAD_BITS;
   localparam int SQRT_ITERS_PER_STAGE = 2;
   localparam int SQRT_STAGES          =
      (ROOT_BITS + SQRT_ITERS_PER_STAGE - 1) / SQRT_ITERS_PER_STAGE;
   localparam int FRONT_STAGES         = 3;
   localparam int LATENCY              = FRONT_STAGES + SQRT_STAGES + 1;
   localparam int CSR_IDX_BITS         = 3;
   localparam int EXT_BITS             = COORD_BITS + 2;

   localparam logic signed [EXT_BITS-1:0] SAT_HI =
      EXT_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [EXT_BITS-1:0] SAT_LO = -SAT_HI - EXT_BITS'(1);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RECT_LEFT     = 3'd0,
      CSR_RECT_TOP      = 3'd1,
      CSR_RECT_WIDTH    = 3'd2,
      CSR_RECT_HEIGHT   = 3'd3,
      CSR_CORNER_RADIUS = 3'd4
   } csr_idx_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [SIZE_BITS-1:0]         size_type;
   typedef logic [RAD_BITS-1:0]          rad_type;
   typedef logic [SQ_BITS-1:0]           sq_type;
   typedef logic [ROOT_BITS-1:0]         root_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      size_type  width;
      size_type  height;
      size_type  radius;
   } cfg_type;

   // row classification carried alongside the root
   typedef struct packed {
      logic    in_rect;
      logic    corner;
      logic    body_ok;
      rad_type r;
   } side_type;

endpackage

FILE: rtl/rrsg_if.sv
interface rrsg_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rrsg_pkg::COORD_BITS-1:0] row_y;

   modport source (output valid, output row_y, input ready);
   modport sink   (input valid, input row_y, output ready);
endinterface

interface rrsg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                span_valid;
   logic signed [rrsg_pkg::COORD_BITS-1:0] span_left;
   logic signed [rrsg_pkg::COORD_BITS-1:0] span_right;

   modport source (output valid, output span_valid, output span_left, output span_right,
                   input ready);
   modport sink   (input valid, input span_valid, input span_left, input span_right,
                   output ready);
endinterface

interface rrsg_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [rrsg_pkg::CSR_IDX_BITS-1:0]    idx;
   logic [rrsg_pkg::COORD_BITS-1:0]      wdata;

   modport source (output valid, output idx, output wdata, input ready);
   modport sink   (input valid, input idx, input wdata, output ready);
endinterface

FILE: rtl/rrsg_csr.sv
module rrsg_csr (
   input  logic              clock,
   input  logic              reset,
   rrsg_csr_if.sink          csr_ch,
   output rrsg_pkg::cfg_type cfg
);

   rrsg_pkg::cfg_type cfg_ff;
   rrsg_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (rrsg_pkg::csr_idx_type'(csr_ch.idx))
            rrsg_pkg::CSR_RECT_LEFT:     cfg_in.left   = csr_ch.wdata;
            rrsg_pkg::CSR_RECT_TOP:      cfg_in.top    = csr_ch.wdata;
            rrsg_pkg::CSR_RECT_WIDTH:    cfg_in.width  = csr_ch.wdata[rrsg_pkg::SIZE_BITS-1:0];
            rrsg_pkg::CSR_RECT_HEIGHT:   cfg_in.height = csr_ch.wdata[rrsg_pkg::SIZE_BITS-1:0];
            rrsg_pkg::CSR_CORNER_RADIUS: cfg_in.radius = csr_ch.wdata[rrsg_pkg::SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left   <= '0;
         cfg_ff.top    <= '0;
         cfg_ff.width  <= rrsg_pkg::SIZE_BITS'(1);
         cfg_ff.height <= rrsg_pkg::SIZE_BITS'(1);
         cfg_ff.radius <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/rrsg_front.sv
module rrsg_front (
   input  logic               clock,
   input  logic               reset,
   input  rrsg_pkg::cfg_type  cfg,
   rrsg_req_if.sink           req_ch,
   output logic               out_valid,
   input  logic               out_ready,
   output rrsg_pkg::sq_type   out_n,
   output rrsg_pkg::side_type out_side
);

   localparam int CB = rrsg_pkg::COORD_BITS;
   localparam int SB = rrsg_pkg::SIZE_BITS;
   localparam int RB = rrsg_pkg::RAD_BITS;
   localparam int QB = rrsg_pkg::SQ_BITS;

   // stage A: captured row
   logic                      va_ff;
   rrsg_pkg::coord_type       row_ff;
   // stage B: row classification
   logic                      vb_ff;
   rrsg_pkg::side_type        side_b_ff;
   rrsg_pkg::rad_type         k_b_ff;
   // stage C: radicand
   logic                      vc_ff;
   rrsg_pkg::side_type        side_c_ff;
   rrsg_pkg::sq_type          n_ff;

   logic en_a, en_b, en_c;

   logic signed [CB:0]   ry;
   logic [SB-1:0]        ry_near;
   logic [SB-1:0]        ry_far;
   logic [SB-1:0]        k_in;
   logic [RB-1:0]        half_w, half_h, r_w, r_in;
   rrsg_pkg::side_type   side_b_in;
   logic [RB:0]          span_b;
   logic [QB:0]          prod;
   rrsg_pkg::sq_type     n_in;

   assign en_c         = !vc_ff || out_ready;
   assign en_b         = !vb_ff || en_c;
   assign en_a         = !va_ff || en_b;
   assign req_ch.ready = en_a;

   always_comb begin
      ry      = $signed({row_ff[CB-1], row_ff}) - $signed({cfg.top[CB-1], cfg.top});
      ry_near = ry[SB-1:0];
      ry_far  = cfg.height - SB'(1) - ry_near;
      k_in    = (ry_far < ry_near) ? ry_far : ry_near;
      half_w  = cfg.width[SB-1:1];
      half_h  = cfg.height[SB-1:1];
      r_w     = (cfg.radius < {1'b0, half_w}) ? cfg.radius[RB-1:0] : half_w;
      r_in    = (r_w < half_h) ? r_w : half_h;

      side_b_in.in_rect = (cfg.width != '0) && (cfg.height != '0) && !ry[CB]
                          && (ry[CB-1:0] < CB'(cfg.height));
      side_b_in.corner  = k_in < {1'b0, r_in};
      side_b_in.body_ok = {1'b0, cfg.width} > {1'b0, r_in, 1'b0};
      side_b_in.r       = r_in;
   end

   // r^2 - (r-k)^2 = k * (2r - k)
   always_comb begin
      span_b = {side_b_ff.r, 1'b0} - {1'b0, k_b_ff};
      prod   = k_b_ff * span_b;
      n_in   = side_b_ff.corner ? prod[QB-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= req_ch.valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
      end
      if (en_a && req_ch.valid) row_ff <= req_ch.row_y;
      if (en_b && va_ff) begin
         side_b_ff <= side_b_in;
         k_b_ff    <= k_in[RB-1:0];
      end
      if (en_c && vb_ff) begin
         side_c_ff <= side_b_ff;
         n_ff      <= n_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_n     = n_ff;
   assign out_side  = side_c_ff;

endmodule

FILE: rtl/rrsg_isqrt.sv
module rrsg_isqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rrsg_pkg::sq_type   in_n,
   input  rrsg_pkg::side_type in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output rrsg_pkg::root_type out_root,
   output rrsg_pkg::side_type out_side
);

   localparam int NS = rrsg_pkg::SQRT_STAGES;
   localparam int NI = rrsg_pkg::SQRT_ITERS_PER_STAGE;
   localparam int QB = rrsg_pkg::SQ_BITS;
   localparam int RB = rrsg_pkg::ROOT_BITS;

   logic               v_ff    [NS];
   logic [QB-1:0]      rem_ff  [NS];
   logic [QB:0]        root_ff [NS];
   rrsg_pkg::side_type side_ff [NS];
   logic               en      [NS+1];

   assign en[NS] = out_ready;

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic               src_valid;
      logic [QB-1:0]      src_rem;
      logic [QB:0]        src_root;
      rrsg_pkg::side_type src_side;
      logic [QB-1:0]      rem_in;
      logic [QB:0]        root_in;

      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_n;
         assign src_root  = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = v_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_root  = root_ff[s-1];
         assign src_side  = side_ff[s-1];
      end

      assign en[s] = !v_ff[s] || en[s+1];

      // two digit steps of the shift-subtract root
      always_comb begin
         logic [QB:0] step_w;
         logic [QB:0] trial;
         rem_in  = src_rem;
         root_in = src_root;
         for (int j = 0; j < NI; j++) begin
            if (s * NI + j < RB) begin
               step_w = (QB+1)'(1) << (2 * (RB - 1 - (s * NI + j)));
               trial  = root_in + step_w;
               if ({1'b0, rem_in} >= trial) begin
                  rem_in  = rem_in - trial[QB-1:0];
                  root_in = (root_in >> 1) + step_w;
               end else begin
                  root_in = root_in >> 1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= src_valid;
         end
         if (en[s] && src_valid) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= src_side;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];
   assign out_root  = root_ff[NS-1][RB-1:0];
   assign out_side  = side_ff[NS-1];

endmodule

FILE: rtl/rrsg_back.sv
module rrsg_back (
   input  logic               clock,
   input  logic               reset,
   input  rrsg_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  rrsg_pkg::root_type in_root,
   input  rrsg_pkg::side_type in_side,
   rrsg_rsp_if.source         rsp_ch
);

   localparam int CB = rrsg_pkg::COORD_BITS;
   localparam int SB = rrsg_pkg::SIZE_BITS;
   localparam int RB = rrsg_pkg::RAD_BITS;
   localparam int EB = rrsg_pkg::EXT_BITS;

   logic                out_v_ff;
   logic                span_valid_ff;
   rrsg_pkg::coord_type span_left_ff;
   rrsg_pkg::coord_type span_right_ff;

   logic                en;
   rrsg_pkg::rad_type   inset;
   logic                span_ok;
   logic signed [EB-1:0] left_ext, width_ext, inset_ext, lft_raw, rgt_raw;
   rrsg_pkg::coord_type lft_in, rgt_in;

   function automatic rrsg_pkg::coord_type sat_coord(input logic signed [EB-1:0] v);
      if (v > rrsg_pkg::SAT_HI) begin
         return rrsg_pkg::SAT_HI[CB-1:0];
      end else if (v < rrsg_pkg::SAT_LO) begin
         return rrsg_pkg::SAT_LO[CB-1:0];
      end
      return v[CB-1:0];
   endfunction

   assign en       = !out_v_ff || rsp_ch.ready;
   assign in_ready = en;

   always_comb begin
      inset     = in_side.corner ? (in_side.r - in_root) : '0;
      span_ok   = in_side.in_rect
                  && (!in_side.corner || (in_root != '0) || in_side.body_ok);
      left_ext  = $signed({{(EB-CB){cfg.left[CB-1]}}, cfg.left});
      width_ext = $signed({{(EB-SB){1'b0}}, cfg.width});
      inset_ext = $signed({{(EB-RB){1'b0}}, inset});
      lft_raw   = left_ext + inset_ext;
      // ~inset = -inset - 1
      rgt_raw   = left_ext + width_ext + ~inset_ext;
      lft_in    = sat_coord(lft_raw);
      rgt_in    = sat_coord(rgt_raw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= in_valid;
      end
      if (en && in_valid) begin
         span_valid_ff  <= span_ok;
         span_left_ff   <= span_ok ? lft_in : '0;
         span_right_ff  <= span_ok ? rgt_in : '0;
      end
   end

   assign rsp_ch.valid      = out_v_ff;
   assign rsp_ch.span_valid = span_valid_ff;
   assign rsp_ch.span_left  = span_left_ff;
   assign rsp_ch.span_right = span_right_ff;

endmodule

FILE: rtl/rounded_rect_row_span_generator.sv
// Each req beat passes 3 front stages, 7 root stages of two digits each
//   and 1 output register on its way to its rsp beat.
// Throughput: one row per cycle while rsp is ready; one root stage per two root bits.
// Stalls hold each stage in place; empty stages still fill while rsp waits.
// Reset (synchronous): clears all stage valids and loads the registers'
//   reset values; the csr port is always ready.
module rounded_rect_row_span_generator (
   input  logic       clock,
   input  logic       reset,
   rrsg_csr_if.sink   csr_ch,
   rrsg_req_if.sink   req_ch,
   rrsg_rsp_if.source rsp_ch
);

   rrsg_pkg::cfg_type  cfg;

   logic               fr_valid, fr_ready;
   rrsg_pkg::sq_type   fr_n;
   rrsg_pkg::side_type fr_side;

   logic               sq_valid, sq_ready;
   rrsg_pkg::root_type sq_root;
   rrsg_pkg::side_type sq_side;

   rrsg_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   rrsg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_ch    (req_ch),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_n     (fr_n),
      .out_side  (fr_side)
   );

   rrsg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_n      (fr_n),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   rrsg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (sq_valid),
      .in_ready (sq_ready),
      .in_root  (sq_root),
      .in_side  (sq_side),
      .rsp_ch   (rsp_ch)
   );

endmodule

FILE: rtl/rrsg_checker.sv
module rrsg_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic                                   span_valid,
   input  logic signed [rrsg_pkg::COORD_BITS-1:0] span_left,
   input  logic signed [rrsg_pkg::COORD_BITS-1:0] span_right
);

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(span_valid)
         && $stable(span_left) && $stable(span_right))
      else $error("rsp beat changed while stalled");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !span_valid |-> span_left == '0 && span_right == '0)
      else $error("empty span carries non-zero ends");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && span_valid |-> span_left <= span_right)
      else $error("span left end beyond right end");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind rounded_rect_row_span_generator rrsg_checker u_rrsg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .span_valid (rsp_ch.span_valid),
   .span_left  (rsp_ch.span_left),
   .span_right (rsp_ch.span_right)
);
